/* rtl/qws_pkg.sv */
// Package for the quoted word splitter: byte codes, quote kinds, register
// indexes and the result record. No dependencies.
package qws_pkg;

    localparam logic [7:0]  BACKSLASH_BYTE = 8'h5C;
    localparam logic [7:0]  DQUOTE_BYTE    = 8'h22;
    localparam logic [7:0]  SQUOTE_BYTE    = 8'h27;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    localparam logic [63:0] SEP_MASK_0_RESET = 64'h0000_0001_0000_0000;

    typedef enum logic [2:0] {
        CFG_SEP_MASK_0  = 3'd0,
        CFG_SEP_MASK_1  = 3'd1,
        CFG_SEP_MASK_2  = 3'd2,
        CFG_SEP_MASK_3  = 3'd3,
        CFG_SINGLE_MODE = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        QK_NONE   = 2'd0,
        QK_DOUBLE = 2'd1,
        QK_SINGLE = 2'd2
    } t_quote;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  out_byte;
        logic        word_end;
        logic        done_res;
        logic [15:0] word_count;
    } t_result;

endpackage

/* rtl/quoted_word_splitter.sv */
// Quoted word splitter top level: tokenizer state, separator set registers
// and a result register with a skid stage. Depends on qws_pkg.
//
// One byte is taken per clock cycle while o_in_stall is low: each request
// updates the quote, escape and collapse flags and the word count, and its
// result (if any) is registered into the output register, or into the skid
// register behind it while the output register holds a result not yet taken;
// o_in_stall rises only when that skid register is occupied.
// Configuration writes are always ready and take effect on the next request.
module quoted_word_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_has_byte,
    output logic [7:0]  o_out_byte,
    output logic        o_word_end,
    output logic        o_done_res,
    output logic [15:0] o_word_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0]     r_sep_mask [4];
    logic            r_single_mode;

    qws_pkg::t_quote r_quote, n_quote;
    logic            r_escape, n_escape;
    logic            r_skipping, n_skipping;
    logic            r_nonempty, n_nonempty;
    logic            r_quoted, n_quoted;
    logic [15:0]     r_words, n_words;

    qws_pkg::t_result r_out, r_skid, w_res;
    logic             r_out_valid, r_skid_valid;
    logic             w_res_valid;

    logic [255:0]    w_sep_set;
    logic            w_is_sep;
    logic [15:0]     w_bumped;
    qws_pkg::t_quote w_q;
    logic            w_accept;
    logic            w_take;

    assign w_sep_set   = {r_sep_mask[3], r_sep_mask[2], r_sep_mask[1], r_sep_mask[0]};
    assign w_is_sep    = w_sep_set[i_in_byte];
    assign w_bumped    = (r_words != qws_pkg::COUNT_MAX) ? r_words + 16'd1 : r_words;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign w_take      = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_in_byte == qws_pkg::DQUOTE_BYTE) begin
            w_q = qws_pkg::QK_DOUBLE;
        end else if (i_in_byte == qws_pkg::SQUOTE_BYTE) begin
            w_q = qws_pkg::QK_SINGLE;
        end else begin
            w_q = qws_pkg::QK_NONE;
        end
    end

    always_comb begin
        n_quote     = r_quote;
        n_escape    = r_escape;
        n_skipping  = r_skipping;
        n_nonempty  = r_nonempty;
        n_quoted    = r_quoted;
        n_words     = r_words;
        w_res       = '0;
        w_res_valid = 1'b0;
        if (i_end_of_text) begin
            w_res_valid      = 1'b1;
            w_res.done_res   = 1'b1;
            w_res.word_end   = r_nonempty || r_quoted;
            w_res.word_count = (r_nonempty || r_quoted) ? w_bumped : r_words;
            n_quote          = qws_pkg::QK_NONE;
            n_escape         = 1'b0;
            n_skipping       = 1'b0;
            n_nonempty       = 1'b0;
            n_quoted         = 1'b0;
            n_words          = '0;
        end else if (r_skipping && w_is_sep) begin
            // drop separator inside a collapse run
        end else begin
            n_skipping = 1'b0;
            if (r_escape) begin
                n_escape       = 1'b0;
                n_nonempty     = 1'b1;
                w_res_valid    = 1'b1;
                w_res.has_byte = 1'b1;
                w_res.out_byte = i_in_byte;
            end else if (i_in_byte == qws_pkg::BACKSLASH_BYTE) begin
                n_escape = 1'b1;
            end else if (r_quote != qws_pkg::QK_NONE && w_q == r_quote) begin
                n_quote = qws_pkg::QK_NONE;
            end else if (r_quote == qws_pkg::QK_NONE && w_q != qws_pkg::QK_NONE) begin
                n_quote  = w_q;
                n_quoted = 1'b1;
            end else if (r_quote == qws_pkg::QK_NONE && w_is_sep) begin
                n_words        = w_bumped;
                n_nonempty     = 1'b0;
                n_quoted       = 1'b0;
                n_skipping     = !r_single_mode;
                w_res_valid    = 1'b1;
                w_res.word_end = 1'b1;
            end else begin
                n_nonempty     = 1'b1;
                w_res_valid    = 1'b1;
                w_res.has_byte = 1'b1;
                w_res.out_byte = i_in_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_mask[0] <= qws_pkg::SEP_MASK_0_RESET;
            r_sep_mask[1] <= '0;
            r_sep_mask[2] <= '0;
            r_sep_mask[3] <= '0;
            r_single_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qws_pkg::CFG_SEP_MASK_0:  r_sep_mask[0] <= i_cfg_data;
                qws_pkg::CFG_SEP_MASK_1:  r_sep_mask[1] <= i_cfg_data;
                qws_pkg::CFG_SEP_MASK_2:  r_sep_mask[2] <= i_cfg_data;
                qws_pkg::CFG_SEP_MASK_3:  r_sep_mask[3] <= i_cfg_data;
                qws_pkg::CFG_SINGLE_MODE: r_single_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote    <= qws_pkg::QK_NONE;
            r_escape   <= 1'b0;
            r_skipping <= 1'b0;
            r_nonempty <= 1'b0;
            r_quoted   <= 1'b0;
            r_words    <= '0;
        end else if (w_accept) begin
            r_quote    <= n_quote;
            r_escape   <= n_escape;
            r_skipping <= n_skipping;
            r_nonempty <= n_nonempty;
            r_quoted   <= n_quoted;
            r_words    <= n_words;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_valid <= w_accept && w_res_valid;
            r_out       <= w_res;
        end else if (w_accept && w_res_valid) begin
            r_skid       <= w_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_has_byte   = r_out.has_byte;
    assign o_out_byte   = r_out.out_byte;
    assign o_word_end   = r_out.word_end;
    assign o_done_res   = r_out.done_res;
    assign o_word_count = r_out.word_count;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_count_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done_res) |-> (r_out.word_count == 16'd0))
        else $error("word count shown on a result that is not an end result");

    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_end_of_text) |=>
        (r_quote == qws_pkg::QK_NONE && r_words == 16'd0 && !r_escape && !r_skipping))
        else $error("string state not cleared after end request");

    a_byte_xor_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.has_byte && (r_out.word_end || r_out.done_res)))
        else $error("result carries a word byte together with a word end");

endmodule

/* test/tb_quoted_word_splitter.sv */
// Testbench for quoted_word_splitter: directed strings and random traffic
// with random idling, checked against an in-bench tokenizer.
// Depends on qws_pkg and the quoted_word_splitter RTL.
`timescale 1ns / 100ps

module tb_quoted_word_splitter;

    localparam int IDLE_LIMIT = 2000;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_end_of_text;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_has_byte;
    logic [7:0]  o_out_byte;
    logic        o_word_end;
    logic        o_done_res;
    logic [15:0] o_word_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    quoted_word_splitter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_has_byte    (o_has_byte),
        .o_out_byte    (o_out_byte),
        .o_word_end    (o_word_end),
        .o_done_res    (o_done_res),
        .o_word_count  (o_word_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // tokenizer state and separator configuration
    logic [255:0]     sep_set = {192'b0, qws_pkg::SEP_MASK_0_RESET};
    logic             single_sep = 1'b0;
    qws_pkg::t_quote  open_quote = qws_pkg::QK_NONE;
    logic             esc_armed = 1'b0;
    logic             run_skip = 1'b0;
    logic             word_has_bytes = 1'b0;
    logic             word_quoted = 1'b0;
    logic [15:0]      word_total = '0;

    qws_pkg::t_result token_q[$];
    qws_pkg::t_result want;
    qws_pkg::t_result pred;
    int               n_errors = 0;
    int               tx_idle_pct = 0;
    int               rx_stall_pct = 0;
    int               idle_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void count_word();
        if (word_total != qws_pkg::COUNT_MAX) word_total++;
    endfunction

    function automatic bit split_byte(input logic [7:0] b, input logic eot,
                                      output qws_pkg::t_result r);
        qws_pkg::t_quote qb;
        r = '0;
        if (eot) begin
            if (word_has_bytes || word_quoted) begin
                count_word();
                r.word_end = 1'b1;
            end
            r.done_res   = 1'b1;
            r.word_count = word_total;
            open_quote     = qws_pkg::QK_NONE;
            esc_armed      = 1'b0;
            run_skip       = 1'b0;
            word_has_bytes = 1'b0;
            word_quoted    = 1'b0;
            word_total     = '0;
            return 1'b1;
        end
        if (run_skip) begin
            if (sep_set[b]) return 1'b0;
            run_skip = 1'b0;
        end
        if (esc_armed) begin
            esc_armed      = 1'b0;
            word_has_bytes = 1'b1;
            r.has_byte     = 1'b1;
            r.out_byte     = b;
            return 1'b1;
        end
        if (b == qws_pkg::BACKSLASH_BYTE) begin
            esc_armed = 1'b1;
            return 1'b0;
        end
        if (b == qws_pkg::DQUOTE_BYTE) qb = qws_pkg::QK_DOUBLE;
        else if (b == qws_pkg::SQUOTE_BYTE) qb = qws_pkg::QK_SINGLE;
        else qb = qws_pkg::QK_NONE;
        if (open_quote != qws_pkg::QK_NONE && qb == open_quote) begin
            open_quote = qws_pkg::QK_NONE;
            return 1'b0;
        end
        if (open_quote == qws_pkg::QK_NONE && qb != qws_pkg::QK_NONE) begin
            open_quote  = qb;
            word_quoted = 1'b1;
            return 1'b0;
        end
        if (open_quote == qws_pkg::QK_NONE && sep_set[b]) begin
            count_word();
            word_has_bytes = 1'b0;
            word_quoted    = 1'b0;
            if (!single_sep) run_skip = 1'b1;
            r.word_end = 1'b1;
            return 1'b1;
        end
        word_has_bytes = 1'b1;
        r.has_byte     = 1'b1;
        r.out_byte     = b;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (qws_pkg::t_cfg_index'(i_cfg_index))
                qws_pkg::CFG_SEP_MASK_0:  sep_set[63:0]    <= i_cfg_data;
                qws_pkg::CFG_SEP_MASK_1:  sep_set[127:64]  <= i_cfg_data;
                qws_pkg::CFG_SEP_MASK_2:  sep_set[191:128] <= i_cfg_data;
                qws_pkg::CFG_SEP_MASK_3:  sep_set[255:192] <= i_cfg_data;
                qws_pkg::CFG_SINGLE_MODE: single_sep       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (split_byte(i_in_byte, i_end_of_text, pred)) token_q.push_back(pred);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0h", $time,
                         {o_has_byte, o_out_byte, o_word_end, o_done_res, o_word_count});
                n_errors++;
            end else begin
                want = token_q.pop_front();
                check_field("has_byte", 16'(want.has_byte), 16'(o_has_byte));
                check_field("out_byte", 16'(want.out_byte), 16'(o_out_byte));
                check_field("word_end", 16'(want.word_end), 16'(o_word_end));
                check_field("done_res", 16'(want.done_res), 16'(o_done_res));
                check_field("word_count", want.word_count, o_word_count);
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("quoted_word_splitter test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_req(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_req(8'($urandom_range(255)), 1'b1);
    endtask

    // drop valid, wait out every pending result, then let the pipe go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input qws_pkg::t_cfg_index idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [63:0] m0, input logic [63:0] m1,
                              input logic [63:0] m2, input logic [63:0] m3,
                              input logic single);
        settle();
        write_reg(qws_pkg::CFG_SEP_MASK_0, m0);
        write_reg(qws_pkg::CFG_SEP_MASK_1, m1);
        write_reg(qws_pkg::CFG_SEP_MASK_2, m2);
        write_reg(qws_pkg::CFG_SEP_MASK_3, m3);
        write_reg(qws_pkg::CFG_SINGLE_MODE, {63'b0, single});
    endtask

    function automatic logic [7:0] pick_sep();
        logic [7:0] b;
        for (int i = 0; i < 16; i++) begin
            b = 8'($urandom_range(255));
            if (sep_set[b]) return b;
        end
        return SPACE_BYTE;
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 8'(8'h61 + $urandom_range(25));
        if (r < 60) return pick_sep();
        if (r < 70) return qws_pkg::DQUOTE_BYTE;
        if (r < 78) return qws_pkg::SQUOTE_BYTE;
        if (r < 86) return qws_pkg::BACKSLASH_BYTE;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [63:0] sparse_mask();
        return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endfunction

    task automatic run_random(input int n_items);
        int  sent;
        int  len;
        bit  noisy;
        sent = 0;
        while (sent < n_items) begin
            noisy = ($urandom_range(9) == 0);
            len   = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(12);
            for (int i = 0; i < len; i++) begin
                send_req(noisy ? 8'($urandom_range(255)) : pick_text_byte(), 1'b0);
            end
            send_end();
            sent += len + 1;
        end
    endtask

    task automatic test_default_splitting();
        tx_idle_pct  = 38;
        rx_stall_pct = 76;
        send_text(" a  \" \"b\\ c");
        send_end();
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_text("'\"\\");
        send_end();
    endtask

    task automatic test_single_mode();
        set_config(qws_pkg::SEP_MASK_0_RESET, '0, '0, '0, 1'b1);
        send_text("  a");
        send_end();
    endtask

    task automatic test_mode_change_in_run();
        set_config(qws_pkg::SEP_MASK_0_RESET, '0, '0, '0, 1'b0);
        send_text("a ");
        settle();
        write_reg(qws_pkg::CFG_SINGLE_MODE, 64'd1);
        send_text(" b  ");
        send_end();
    endtask

    task automatic test_quotes_in_collapse_run();
        set_config(qws_pkg::SEP_MASK_0_RESET | (64'd1 << qws_pkg::DQUOTE_BYTE),
                   64'd1 << (qws_pkg::BACKSLASH_BYTE - 64), '0, '0, 1'b0);
        send_text("a \"\\b");
        send_end();
    endtask

    task automatic test_extreme_masks();
        tx_idle_pct  = 38;
        rx_stall_pct = 76;
        set_config('1, '1, '1, '1, 1'b1);
        run_random(40);
        set_config('0, '0, '0, '0, 1'b0);
        run_random(40);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input logic single);
        set_config(sparse_mask() | qws_pkg::SEP_MASK_0_RESET, sparse_mask(), sparse_mask(),
                   sparse_mask(), single);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        run_random(225);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_byte     <= '0;
        i_end_of_text <= 1'b0;
        i_out_stall   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= qws_pkg::CFG_SEP_MASK_0;
        i_cfg_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_splitting();
        test_single_mode();
        test_mode_change_in_run();
        test_quotes_in_collapse_run();
        test_extreme_masks();
        test_random_traffic(38, 76, 1'b0);
        test_random_traffic(76, 38, 1'b1);
        test_random_traffic(0, 0, 1'($urandom_range(1)));
        settle();

        if (token_q.size() != 0) begin
            $display("%0t: results missing, expected %0d more actual 0", $time, token_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("quoted_word_splitter test passed");
        end else begin
            $display("quoted_word_splitter test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/qws_pkg.sv
rtl/quoted_word_splitter.sv
test/tb_quoted_word_splitter.sv
